// File: sv/lazy_status_flags_unit_top_defines.svh
// Assertion macros used by the flags unit top level.
`ifndef LAZY_STATUS_FLAGS_UNIT_TOP_DEFINES_SVH
`define LAZY_STATUS_FLAGS_UNIT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSFU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LSFU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lsfu_pkg.sv
// Types and constants of the lazy flags unit.
`timescale 1ns / 1ps
package lsfu_pkg;

  // item opcodes
  localparam logic [2:0] OPC_RECORD = 3'd0;
  localparam logic [2:0] OPC_READ   = 3'd1;
  localparam logic [2:0] OPC_WR_ALL = 3'd2;
  localparam logic [2:0] OPC_WR_ARI = 3'd3;
  localparam logic [2:0] OPC_SET1   = 3'd4;
  localparam logic [2:0] OPC_SSZP   = 3'd5;

  // recorded operation kinds
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_ADC = 3'd1;
  localparam logic [2:0] KIND_SUB = 3'd2;
  localparam logic [2:0] KIND_SBB = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  // flag select codes, also bit index into the settled vector
  localparam logic [3:0] FS_CF = 4'd0;
  localparam logic [3:0] FS_PF = 4'd1;
  localparam logic [3:0] FS_AF = 4'd2;
  localparam logic [3:0] FS_ZF = 4'd3;
  localparam logic [3:0] FS_SF = 4'd4;
  localparam logic [3:0] FS_TF = 4'd5;
  localparam logic [3:0] FS_IF = 4'd6;
  localparam logic [3:0] FS_DF = 4'd7;
  localparam logic [3:0] FS_OF = 4'd8;

  // pending vector bit positions
  localparam int unsigned PEND_CF = 0;
  localparam int unsigned PEND_PF = 1;
  localparam int unsigned PEND_AF = 2;
  localparam int unsigned PEND_ZF = 3;
  localparam int unsigned PEND_SF = 4;
  localparam int unsigned PEND_OF = 5;

  localparam logic [15:0] MASK_W16 = 16'hFFFF;
  localparam logic [15:0] MASK_W8  = 16'h00FF;
  localparam logic [8:0]  SETTLED_RST = 9'h015;  // SF, AF, CF set

  typedef struct packed {
    logic [2:0]  kind;
    logic        w16;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] r;
  } op_rec_t;

  typedef struct packed {
    op_rec_t     of_rec;
    op_rec_t     cf_rec;
    op_rec_t     af_rec;
    logic [7:0]  parity_res;
    logic        sign_w16;
    logic [15:0] sign_val;
    logic [15:0] zero_res;
    logic [5:0]  pend;
    logic [8:0]  settled;
    logic [3:0]  upper;
  } lsfu_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  op_kind;
    logic        width_16;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [15:0] result_value;
    logic [11:0] flag_mask;
    logic [15:0] flag_word;
    logic [3:0]  flag_select;
    logic        flag_value;
  } lsfu_item_t;

endpackage

// File: sv/lsfu_if.sv
// Input and result channel interfaces of the flags unit.
`timescale 1ns / 1ps
interface lsfu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  op_kind;
  logic        width_16;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic [15:0] result_value;
  logic [11:0] flag_mask;
  logic [15:0] flag_word;
  logic [3:0]  flag_select;
  logic        flag_value;

  modport source (
    output valid, opcode, op_kind, width_16, operand_a, operand_b,
           result_value, flag_mask, flag_word, flag_select, flag_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, op_kind, width_16, operand_a, operand_b,
           result_value, flag_mask, flag_word, flag_select, flag_value,
    output ready
  );
endinterface

interface lsfu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] flags_out;

  modport source (output valid, flags_out, input ready);
  modport sink (input valid, flags_out, output ready);
endinterface

// File: sv/lazy_status_flags_unit_top.sv
// Lazy-evaluated 8086-style flags unit, top level.
// The result word is registered into the output buffer at its accept edge.
// Throughput: one item per cycle while the skid slot is free, set by the single state update path.
// A two-entry output buffer keeps input accepting while one result waits unread.
// Reset (rst_n low, synchronous): records and pending marks clear, SF AF CF settled set.
// Output buffer empties on reset, no clearing pass.
`timescale 1ns / 1ps
`include "lazy_status_flags_unit_top_defines.svh"
module lazy_status_flags_unit_top
  import lsfu_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  lsfu_in_if.sink         in_ch,
  lsfu_out_if.source      out_ch
);

  lsfu_item_t  item;
  lsfu_state_t st;
  logic [15:0] word;
  logic        accept;

  // pack the channel payload into one item
  assign item.opcode       = in_ch.opcode;
  assign item.op_kind      = in_ch.op_kind;
  assign item.width_16     = in_ch.width_16;
  assign item.operand_a    = in_ch.operand_a;
  assign item.operand_b    = in_ch.operand_b;
  assign item.result_value = in_ch.result_value;
  assign item.flag_mask    = in_ch.flag_mask;
  assign item.flag_word    = in_ch.flag_word;
  assign item.flag_select  = in_ch.flag_select;
  assign item.flag_value   = in_ch.flag_value;

  // an item updates the state at its accept edge; the word built from the
  // updated state goes straight into the output buffer the same edge
  assign accept = in_ch.valid & in_ch.ready;

  lsfu_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .st_o   (st),
    .word_o (word)
  );

  // ready depends only on the skid slot, never on out_ch.ready
  lsfu_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (in_ch.ready),
    .push_data  (word),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (out_ch.flags_out)
  );

  // a read settles everything
  `LSFU_ASSERT_NXT(a_read_clears_pend, accept && (in_ch.opcode == OPC_READ), st.pend == 6'd0, "pending left after read")
  // write all loads the upper nibble
  `LSFU_ASSERT_NXT(a_wr_all_upper, accept && (in_ch.opcode == OPC_WR_ALL), st.upper == $past(in_ch.flag_word[15:12]), "upper nibble not loaded")
  // stalled input only while a result is held
  `LSFU_ASSERT_IMP(a_stall_has_result, !in_ch.ready, out_ch.valid, "input stalled with empty output")
  // fixed bits of the word image
  `LSFU_ASSERT_IMP(a_fixed_bits, out_ch.valid, out_ch.flags_out[1] && !out_ch.flags_out[3] && !out_ch.flags_out[5], "fixed flag bits wrong")

endmodule

// File: sv/lsfu_eval.sv
// Resolves pending flags from their stored records.
`timescale 1ns / 1ps
module lsfu_eval
  import lsfu_pkg::*;
(
  input  lsfu_state_t st,
  output logic [8:0]  flags
);

  function automatic logic eval_of(input op_rec_t q);
    logic sa, sb, sr;
    logic v;
    sa = q.w16 ? q.a[15] : q.a[7];
    sb = q.w16 ? q.b[15] : q.b[7];
    sr = q.w16 ? q.r[15] : q.r[7];
    case (q.kind) inside
      KIND_ADD, KIND_ADC:           v = (sa == sb) && (sa != sr);
      KIND_SUB, KIND_SBB, KIND_CMP: v = (sa != sb) && (sb == sr);
      default:                      v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic logic eval_cf(input op_rec_t q);
    logic v;
    case (q.kind) inside
      KIND_ADD:           v = (q.r < q.a) || (q.r < q.b);
      KIND_ADC:           v = (q.r <= q.a);
      KIND_SUB, KIND_CMP: v = (q.a < q.b);
      KIND_SBB:           v = (q.a < q.r) || (q.b == (q.w16 ? MASK_W16 : MASK_W8));
      default:            v = 1'b0;
    endcase
    return v;
  endfunction

  always_comb begin
    flags = st.settled;
    if (st.pend[PEND_CF]) flags[FS_CF] = eval_cf(st.cf_rec);
    if (st.pend[PEND_PF]) flags[FS_PF] = ~(^st.parity_res);
    if (st.pend[PEND_AF]) flags[FS_AF] = st.af_rec.a[4] ^ st.af_rec.b[4] ^ st.af_rec.r[4];
    if (st.pend[PEND_ZF]) flags[FS_ZF] = (st.zero_res == 16'd0);
    if (st.pend[PEND_SF]) flags[FS_SF] = st.sign_w16 ? st.sign_val[15] : st.sign_val[7];
    if (st.pend[PEND_OF]) flags[FS_OF] = eval_of(st.of_rec);
  end

endmodule

// File: sv/lsfu_state.sv
// Flags state registers, item decode and result word build.
`timescale 1ns / 1ps
module lsfu_state
  import lsfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  lsfu_item_t  item,
  output lsfu_state_t st_o,
  output logic [15:0] word_o
);

  lsfu_state_t st_r, st_nxt;
  lsfu_state_t st_rst;
  logic [8:0]  cur_flags, nxt_flags;
  logic [15:0] wmask, res_m;
  op_rec_t     rec;
  logic [15:0] fw;

  lsfu_eval u_eval_cur (.st(st_r),   .flags(cur_flags));
  lsfu_eval u_eval_nxt (.st(st_nxt), .flags(nxt_flags));

  assign wmask = item.width_16 ? MASK_W16 : MASK_W8;
  assign res_m = item.result_value & wmask;
  assign fw    = item.flag_word;

  // reset image: everything clear except the settled SF, AF, CF
  always_comb begin
    st_rst         = '0;
    st_rst.settled = SETTLED_RST;
  end

  always_comb begin
    rec.kind = item.op_kind;
    rec.w16  = item.width_16;
    rec.a    = item.operand_a & wmask;
    rec.b    = item.operand_b & wmask;
    rec.r    = res_m;
  end

  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      unique case (item.opcode)
        OPC_RECORD: begin
          if (item.flag_mask[7]) begin
            st_nxt.sign_w16      = item.width_16;
            st_nxt.sign_val      = res_m;
            st_nxt.pend[PEND_SF] = 1'b1;
          end
          if (item.flag_mask[6]) begin
            st_nxt.zero_res      = res_m;
            st_nxt.pend[PEND_ZF] = 1'b1;
          end
          if (item.flag_mask[2]) begin
            st_nxt.parity_res    = res_m[7:0];
            st_nxt.pend[PEND_PF] = 1'b1;
          end
          if (item.flag_mask[0]) begin
            st_nxt.cf_rec        = rec;
            st_nxt.pend[PEND_CF] = 1'b1;
          end
          if (item.flag_mask[11]) begin
            st_nxt.of_rec        = rec;
            st_nxt.pend[PEND_OF] = 1'b1;
          end
          if (item.flag_mask[4]) begin
            st_nxt.af_rec        = rec;
            st_nxt.pend[PEND_AF] = 1'b1;
          end
        end
        OPC_READ: begin
          st_nxt.settled = cur_flags;
          st_nxt.pend    = '0;
        end
        OPC_WR_ALL: begin
          st_nxt.settled = {fw[11], fw[10], fw[9], fw[8], fw[7], fw[6], fw[4], fw[2], fw[0]};
          st_nxt.pend    = '0;
          st_nxt.upper   = fw[15:12];
        end
        OPC_WR_ARI: begin
          st_nxt.settled[4:0] = {fw[7], fw[6], fw[4], fw[2], fw[0]};
          st_nxt.pend[4:0]    = '0;
        end
        OPC_SET1: begin
          if (item.flag_select <= FS_OF) begin
            st_nxt.settled[item.flag_select] = item.flag_value;
          end
          if (item.flag_select <= FS_SF) begin
            st_nxt.pend[item.flag_select[2:0]] = 1'b0;
          end else if (item.flag_select == FS_OF) begin
            st_nxt.pend[PEND_OF] = 1'b0;
          end
        end
        OPC_SSZP: begin
          st_nxt.settled[FS_ZF] = (res_m == 16'd0);
          st_nxt.settled[FS_SF] = item.width_16 ? res_m[15] : res_m[7];
          st_nxt.settled[FS_PF] = ~(^res_m[7:0]);
          st_nxt.pend[PEND_ZF]  = 1'b0;
          st_nxt.pend[PEND_SF]  = 1'b0;
          st_nxt.pend[PEND_PF]  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else begin
      st_r <= st_nxt;
    end
  end

  // word image: OF DF IF TF SF ZF 0 AF 0 PF 1 CF under the upper nibble
  assign word_o = {st_nxt.upper, nxt_flags[FS_OF], nxt_flags[FS_DF], nxt_flags[FS_IF],
                   nxt_flags[FS_TF], nxt_flags[FS_SF], nxt_flags[FS_ZF], 1'b0,
                   nxt_flags[FS_AF], 1'b0, nxt_flags[FS_PF], 1'b1, nxt_flags[FS_CF]};
  assign st_o   = st_r;

endmodule

// File: sv/lsfu_skid.sv
// Two-entry result register with skid stage.
`timescale 1ns / 1ps
module lsfu_skid (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  logic [15:0] push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output logic [15:0] pop_data
);

  logic        main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  logic [15:0] main_r, main_nxt, skid_r, skid_nxt;
  logic        push, pop;

  assign push_ready = ~skid_v_r;
  assign push       = push_valid & push_ready;
  assign pop        = main_v_r & pop_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    main_nxt   = main_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign pop_valid = main_v_r;
  assign pop_data  = main_r;

endmodule
